[hdl/nps_pkg.sv]
package nps_pkg;

	localparam int ARRIVAL_W = 16;
	localparam int BURST_W = 12;
	localparam int PRIO_W = 8;
	localparam int JOB_W = 5;
	localparam int TIME_W = 17;

	localparam int MAX_PROCESSES_DEF = 16;

endpackage

[hdl/nonpreemptive_priority_scheduler_core.sv]
// Channel   Handshake                 Payload
// -------   -----------------------   ----------------------------------------------
// job in    start && !busy            arrival_time, burst_time, priority_level, last_job
// block out valid (one-cycle strobe)  is_idle, job_index, start_time, end_time,
//                                     turnaround, waiting, last_block
//
// A job without last_job is stored while the store has room; busy stays low.
// A job with last_job starts the schedule; every Gantt block costs one scan over the n
// stored jobs, one at a time through the single compare unit, followed by an issue
// state; at most 2n blocks for the whole schedule.
// Each block is shown for one cycle with valid high; the receiver cannot stall.
// Asynchronous reset empties the job store and returns the block to waiting for jobs.
module nonpreemptive_priority_scheduler_core
	import nps_pkg::*;
#(
	parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [ARRIVAL_W-1:0] arrival_time,
	input  logic [BURST_W-1:0]   burst_time,
	input  logic [PRIO_W-1:0]    priority_level,
	input  logic                 last_job,
	output logic                 valid,
	output logic                 is_idle,
	output logic [JOB_W-1:0]     job_index,
	output logic [TIME_W-1:0]    start_time,
	output logic [TIME_W-1:0]    end_time,
	output logic [TIME_W-1:0]    turnaround,
	output logic [TIME_W-1:0]    waiting,
	output logic                 last_block
);

	localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_ISSUE = 2'd2;

	logic [1:0] state_q;

	logic [ARRIVAL_W-1:0] arrival_q [MAX_PROCESSES];
	logic [BURST_W-1:0]   burst_q [MAX_PROCESSES];
	logic [PRIO_W-1:0]    prio_q [MAX_PROCESSES];

	logic [MAX_PROCESSES-1:0] finished_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         done_q;
	logic [IDX_W-1:0]         scan_q;
	logic [TIME_W-1:0]        cur_q;

	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [PRIO_W-1:0]    best_prio_q;
	logic [ARRIVAL_W-1:0] best_arr_q;
	logic [BURST_W-1:0]   best_burst_q;
	logic                 pend_found_q;
	logic [ARRIVAL_W-1:0] pend_min_q;

	logic                 valid_q;
	logic                 is_idle_q;
	logic [JOB_W-1:0]     job_index_q;
	logic [TIME_W-1:0]    start_time_q;
	logic [TIME_W-1:0]    end_time_q;
	logic [TIME_W-1:0]    turnaround_q;
	logic [TIME_W-1:0]    waiting_q;
	logic                 last_block_q;

	logic                 accept;
	logic                 store_room;
	logic [ARRIVAL_W-1:0] e_arr;
	logic [BURST_W-1:0]   e_burst;
	logic [PRIO_W-1:0]    e_prio;
	logic                 e_open;
	logic                 e_ready;
	logic                 e_better;
	logic                 e_earlier;
	logic                 scan_last;
	logic [TIME_W-1:0]    job_end;
	logic                 final_job;

	assign accept = start && (state_q == ST_LOAD);
	assign store_room = (count_q < CNT_W'(MAX_PROCESSES));

	// One entry per cycle goes through the shared compare unit.
	always_comb begin
		e_arr = arrival_q[scan_q];
		e_burst = burst_q[scan_q];
		e_prio = prio_q[scan_q];
		e_open = !finished_q[scan_q];
		e_ready = ({1'b0, e_arr} <= cur_q);
		e_better = !found_q || (e_prio < best_prio_q) ||
			((e_prio == best_prio_q) && (e_arr < best_arr_q));
		e_earlier = !pend_found_q || (e_arr < pend_min_q);
		scan_last = ((CNT_W'(scan_q) + CNT_W'(1)) == count_q);
		job_end = cur_q + TIME_W'(best_burst_q);
		final_job = ((done_q + CNT_W'(1)) == count_q);
	end

	always_ff @(posedge clk) begin
		if (accept && store_room) begin
			arrival_q[count_q[IDX_W-1:0]] <= arrival_time;
			burst_q[count_q[IDX_W-1:0]] <= burst_time;
			prio_q[count_q[IDX_W-1:0]] <= priority_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			finished_q <= '0;
			count_q <= '0;
			done_q <= '0;
			scan_q <= '0;
			cur_q <= '0;
			found_q <= 1'b0;
			pend_found_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (store_room) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (last_job) begin
							state_q <= ST_SCAN;
							scan_q <= '0;
							found_q <= 1'b0;
							pend_found_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (e_open) begin
						if (e_ready && e_better) begin
							found_q <= 1'b1;
						end
						if (e_earlier) begin
							pend_found_q <= 1'b1;
						end
					end
					if (scan_last) begin
						state_q <= ST_ISSUE;
					end else begin
						scan_q <= scan_q + IDX_W'(1);
					end
				end
				ST_ISSUE: begin
					valid_q <= 1'b1;
					scan_q <= '0;
					found_q <= 1'b0;
					pend_found_q <= 1'b0;
					if (found_q) begin
						if (final_job) begin
							state_q <= ST_LOAD;
							finished_q <= '0;
							count_q <= '0;
							done_q <= '0;
							cur_q <= '0;
						end else begin
							state_q <= ST_SCAN;
							finished_q[best_idx_q] <= 1'b1;
							done_q <= done_q + CNT_W'(1);
							cur_q <= job_end;
						end
					end else begin
						state_q <= ST_SCAN;
						cur_q <= {1'b0, pend_min_q};
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Candidate and result payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && e_open) begin
			if (e_ready && e_better) begin
				best_idx_q <= scan_q;
				best_prio_q <= e_prio;
				best_arr_q <= e_arr;
				best_burst_q <= e_burst;
			end
			if (e_earlier) begin
				pend_min_q <= e_arr;
			end
		end
		if (state_q == ST_ISSUE) begin
			start_time_q <= cur_q;
			if (found_q) begin
				is_idle_q <= 1'b0;
				job_index_q <= JOB_W'(best_idx_q);
				end_time_q <= job_end;
				turnaround_q <= job_end - TIME_W'(best_arr_q);
				// Waiting time equals start minus arrival.
				waiting_q <= cur_q - TIME_W'(best_arr_q);
				last_block_q <= final_job;
			end else begin
				is_idle_q <= 1'b1;
				job_index_q <= '0;
				end_time_q <= {1'b0, pend_min_q};
				turnaround_q <= '0;
				waiting_q <= '0;
				last_block_q <= 1'b0;
			end
		end
	end

	assign busy = (state_q != ST_LOAD);
	assign valid = valid_q;
	assign is_idle = is_idle_q;
	assign job_index = job_index_q;
	assign start_time = start_time_q;
	assign end_time = end_time_q;
	assign turnaround = turnaround_q;
	assign waiting = waiting_q;
	assign last_block = last_block_q;

endmodule

[hdl/nps_checker.sv]
module nps_checker
	import nps_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 last_job,
	input logic                 valid,
	input logic                 is_idle,
	input logic [JOB_W-1:0]     job_index,
	input logic [TIME_W-1:0]    start_time,
	input logic [TIME_W-1:0]    end_time,
	input logic [TIME_W-1:0]    turnaround,
	input logic [TIME_W-1:0]    waiting,
	input logic                 last_block
);

	a_idle_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && is_idle |-> !last_block)
		else $error("idle block flagged as last block");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && is_idle |-> job_index == '0 && turnaround == '0 && waiting == '0)
		else $error("idle block carries job data");

	// Turnaround minus waiting is the burst, which is also end minus start.
	a_job_span: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !is_idle |->
			TIME_W'(turnaround - waiting) == TIME_W'(end_time - start_time))
		else $error("job block times are inconsistent");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_job |=> busy)
		else $error("final job transfer did not start scheduling");

	a_valid_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy))
		else $error("result strobe without scheduling");

endmodule

bind nonpreemptive_priority_scheduler_core nps_checker u_nps_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.last_job(last_job),
	.valid(valid),
	.is_idle(is_idle),
	.job_index(job_index),
	.start_time(start_time),
	.end_time(end_time),
	.turnaround(turnaround),
	.waiting(waiting),
	.last_block(last_block)
);
